/* rtl/core/tkh_pkg.sv */
// shared types and constants for the top-k min-heap ranker
// no dependencies; imported by tkh_ctrl, tkh_datapath and the top level
`default_nettype none

package tkh_pkg;

  localparam int HeapDepthDefault = 64;
  localparam int MaxCap           = 64;
  localparam int CapW             = 7;
  localparam logic [CapW-1:0] CapReset = 7'd10;

  localparam int TagW   = 16;
  localparam int ScoreW = 32;
  localparam int SumW   = 33;
  localparam int InDataW  = 80;
  localparam int OutDataW = 120;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic signed [ScoreW-1:0] pitch;
    logic signed [ScoreW-1:0] ioi;
    logic signed [SumW-1:0]   sum;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DR_RD,
    ST_DR_EMIT,
    ST_DR_TAIL,
    ST_DR_LOAD,
    ST_EMPTY
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_UP_RD,
    OP_UP_CMP,
    OP_ROOT_RD,
    OP_ROOT_CMP,
    OP_DN_RD,
    OP_DN_CMP,
    OP_DR_RD,
    OP_DR_EMIT,
    OP_DR_TAIL,
    OP_DR_LOAD,
    OP_EMPTY
  } dp_op_e;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic cur_zero;
    logic par_gt;
    logic root_lt;
    logic leaf;
    logic child_lt;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/tkh_datapath.sv */
// heap datapath: entry memory with two read ports, moving-entry register,
// slot pointer, entry count, capacity register and the result register
// depends on tkh_pkg
`default_nettype none

module tkh_datapath import tkh_pkg::*; #(
  parameter int HEAP_DEPTH = HeapDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CapW-1:0]       cfg_wdata_i,
  input  wire logic [InDataW-1:0]    in_data_i,
  input  wire logic                  in_func_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 status_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output entry_t                     out_entry_o,
  output logic                       out_last_o,
  output logic                       out_none_o
);

  localparam int MemDepth = (HEAP_DEPTH < MaxCap) ? HEAP_DEPTH : MaxCap;
  localparam int IdxW     = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int CntW     = $clog2(MemDepth + 1);
  localparam int W2       = IdxW + 2;

  entry_t            heap_q [MemDepth];
  entry_t            rda_q, rdb_q;
  entry_t            hold_q, hold_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CapW-1:0]   cap_q;
  logic [CapW-1:0]   cap_eff;

  logic              out_valid_q, out_valid_d;
  entry_t            out_entry_q, out_entry_d;
  logic              out_last_q, out_last_d;
  logic              out_none_q, out_none_d;

  logic              re_a, re_b, we;
  logic [IdxW-1:0]   raddr_a, raddr_b, waddr;
  entry_t            wdata;

  entry_t            in_entry;
  logic [IdxW-1:0]   par_idx;
  logic [W2-1:0]     l_w, r_w, n_w;
  logic              r_ok, pick_l, pick_r;
  entry_t            min1, child;
  logic [IdxW-1:0]   child_idx;
  logic              out_free;

  // capacity clamped to 1..MemDepth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_q > CapW'(MemDepth)) begin
      cap_eff = CapW'(MemDepth);
    end else begin
      cap_eff = cap_q;
    end
  end

  always_comb begin
    in_entry.tag   = in_data_i[15:0];
    in_entry.pitch = in_data_i[47:16];
    in_entry.ioi   = in_data_i[79:48];
    in_entry.sum   = $signed({in_data_i[47], in_data_i[47:16]})
                   + $signed({in_data_i[79], in_data_i[79:48]});
  end

  assign par_idx = IdxW'((cur_q - IdxW'(1)) >> 1);
  assign l_w     = {1'b0, cur_q, 1'b1};
  assign r_w     = l_w + W2'(1);
  assign n_w     = W2'(count_q);
  assign r_ok    = r_w < n_w;

  // smaller child, left wins ties, only if below the moving entry
  assign pick_l    = rda_q.sum < hold_q.sum;
  assign min1      = pick_l ? rda_q : hold_q;
  assign pick_r    = r_ok && (rdb_q.sum < min1.sum);
  assign child     = pick_r ? rdb_q : rda_q;
  assign child_idx = pick_r ? r_w[IdxW-1:0] : l_w[IdxW-1:0];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.cnt_zero = (count_q == '0);
    status_o.cnt_one  = (count_q == CntW'(1));
    status_o.full     = CapW'(count_q) >= cap_eff;
    status_o.cur_zero = (cur_q == '0);
    status_o.par_gt   = rda_q.sum > hold_q.sum;
    status_o.root_lt  = hold_q.sum > rda_q.sum;
    status_o.leaf     = l_w >= n_w;
    status_o.child_lt = pick_l || pick_r;
    status_o.out_free = out_free;
  end

  always_comb begin
    re_a        = 1'b0;
    re_b        = 1'b0;
    we          = 1'b0;
    raddr_a     = '0;
    raddr_b     = r_w[IdxW-1:0];
    waddr       = cur_q;
    wdata       = hold_q;
    hold_d      = hold_q;
    cur_d       = cur_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_entry_d = out_entry_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        hold_d = in_entry;
        cur_d  = count_q[IdxW-1:0];
        // tail insert grows the count on the accepting edge
        if (in_func_i == FUNC_INSERT && !status_o.full) begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_UP_RD: begin
        if (status_o.cur_zero) begin
          we = 1'b1;
        end else begin
          re_a    = 1'b1;
          raddr_a = par_idx;
        end
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (status_o.par_gt) begin
          wdata = rda_q;
          cur_d = par_idx;
        end
      end
      OP_ROOT_RD, OP_DR_RD: begin
        re_a    = 1'b1;
        raddr_a = '0;
      end
      OP_ROOT_CMP: begin
        cur_d = '0;
      end
      OP_DN_RD: begin
        if (status_o.leaf) begin
          we = 1'b1;
        end else begin
          re_a    = 1'b1;
          re_b    = 1'b1;
          raddr_a = l_w[IdxW-1:0];
        end
      end
      OP_DN_CMP: begin
        we = 1'b1;
        if (status_o.child_lt) begin
          wdata = child;
          cur_d = child_idx;
        end
      end
      OP_DR_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_entry_d = rda_q;
          out_last_d  = status_o.cnt_one;
          out_none_d  = 1'b0;
          count_d     = count_q - CntW'(1);
        end
      end
      OP_DR_TAIL: begin
        re_a    = 1'b1;
        raddr_a = count_q[IdxW-1:0];
      end
      OP_DR_LOAD: begin
        hold_d = rda_q;
        cur_d  = '0;
      end
      OP_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_entry_d = '0;
          out_last_d  = 1'b0;
          out_none_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q      <= hold_d;
    cur_q       <= cur_d;
    out_entry_q <= out_entry_d;
    out_last_q  <= out_last_d;
    out_none_q  <= out_none_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_q[waddr] <= wdata;
    end
    if (re_a) begin
      rda_q <= heap_q[raddr_a];
    end
    if (re_b) begin
      rdb_q <= heap_q[raddr_b];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_entry_q;
  assign out_last_o  = out_last_q;
  assign out_none_o  = out_none_q;

endmodule

`default_nettype wire

/* rtl/core/tkh_ctrl.sv */
// heap controller: state machine sequencing sift-up, root replacement,
// sift-down and drain over the datapath; depends on tkh_pkg
`default_nettype none

module tkh_ctrl import tkh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_func_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   drain_q, drain_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    drain_d    = drain_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (in_func_i == FUNC_DRAIN) begin
            drain_d = 1'b1;
            state_d = status_i.cnt_zero ? ST_EMPTY : ST_DR_RD;
          end else begin
            drain_d = 1'b0;
            state_d = status_i.full ? ST_ROOT_RD : ST_UP_RD;
          end
        end
      end
      ST_UP_RD: begin
        cmd_o.op = OP_UP_RD;
        state_d  = status_i.cur_zero ? ST_IDLE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        cmd_o.op = OP_UP_CMP;
        state_d  = status_i.par_gt ? ST_UP_RD : ST_IDLE;
      end
      ST_ROOT_RD: begin
        cmd_o.op = OP_ROOT_RD;
        state_d  = ST_ROOT_CMP;
      end
      ST_ROOT_CMP: begin
        cmd_o.op = OP_ROOT_CMP;
        state_d  = status_i.root_lt ? ST_DN_RD : ST_IDLE;
      end
      ST_DN_RD: begin
        cmd_o.op = OP_DN_RD;
        if (status_i.leaf) begin
          state_d = drain_q ? ST_DR_RD : ST_IDLE;
        end else begin
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        cmd_o.op = OP_DN_CMP;
        if (status_i.child_lt) begin
          state_d = ST_DN_RD;
        end else begin
          state_d = drain_q ? ST_DR_RD : ST_IDLE;
        end
      end
      ST_DR_RD: begin
        cmd_o.op = OP_DR_RD;
        state_d  = ST_DR_EMIT;
      end
      ST_DR_EMIT: begin
        cmd_o.op = OP_DR_EMIT;
        if (status_i.out_free) begin
          state_d = status_i.cnt_one ? ST_IDLE : ST_DR_TAIL;
        end
      end
      ST_DR_TAIL: begin
        cmd_o.op = OP_DR_TAIL;
        state_d  = ST_DR_LOAD;
      end
      ST_DR_LOAD: begin
        cmd_o.op = OP_DR_LOAD;
        state_d  = ST_DN_RD;
      end
      ST_EMPTY: begin
        cmd_o.op = OP_EMPTY;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/top_k_min_heap_ranker_unit.sv */
// top level of the top-k min-heap ranker: stream ports and packing
// depends on tkh_pkg, tkh_ctrl, tkh_datapath
`default_nettype none

// Keeps the best candidates, ranked by the sum of two Q15.16 scores, in a
// min-heap of up to min(HEAP_DEPTH, 64) entries; the capacity register
// (cfg_we_i / cfg_wdata_i, reset 10) sets how many are kept.
// Input stream: tuser selects insert (0) or drain (1), tdata carries the tag
// and both scores. An insert gives no output transfer. A drain gives one
// transfer per held entry in ascending sum order, tlast on the final one,
// and empties the heap; a drain of an empty heap gives one transfer with
// tuser set and all other fields zero.
// Timing: items are taken one at a time. Each heap level is a registered
// memory read followed by a compare and write back.
// Output register: the next item is accepted while the last result still
// waits; a stalled receiver holds the drain at its next emit.
// Reset empties the heap (count to zero) and restores the capacity to 10;
// no clearing pass is needed.

module top_k_min_heap_ranker_unit import tkh_pkg::*; #(
  parameter int HEAP_DEPTH = HeapDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CapW-1:0]     cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // title_tag [15:0], pitch [47:16], interval [79:48]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // func [0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // out_tag [15:0], out_pitch [47:16], out_ioi [79:48], out_sum [112:80]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // none_held [0]
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;
  entry_t     out_entry;

  tkh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tkh_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_func_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_entry_o (out_entry),
    .out_last_o  (m_axis_tlast),
    .out_none_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, out_entry.sum, out_entry.ioi, out_entry.pitch,
                         out_entry.tag};

endmodule

`default_nettype wire
